### hw/rtl/depthwise_conv3x3_act_defines.svh
// Assertion macros used by dwc_back.sv, the only RTL file that includes them. The enclosing scope provides clk and rst.
`ifndef DEPTHWISE_CONV3X3_ACT_DEFINES_SVH
`define DEPTHWISE_CONV3X3_ACT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/dwc_pkg.sv
`timescale 1ns / 1ps
package dwc_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int KERNEL_SIZE   = 3;
  localparam int NTAPS         = KERNEL_SIZE * KERNEL_SIZE;
  localparam int QUEUE_DEPTH   = 4;
  localparam int ACC_W         = 36;
  localparam int LPROD_W       = ACC_W + 16;

  localparam logic [2:0] CFG_TAPS_A    = 3'd0;
  localparam logic [2:0] CFG_TAPS_B    = 3'd1;
  localparam logic [2:0] CFG_TAP8_BIAS = 3'd2;
  localparam logic [2:0] CFG_ACT_MODE  = 3'd3;
  localparam logic [2:0] CFG_ACT_PARAM = 3'd4;
  localparam logic [2:0] CFG_WIDTH     = 3'd5;
  localparam logic [2:0] CFG_HEIGHT    = 3'd6;
  localparam logic [2:0] CFG_PADDING   = 3'd7;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RELU  = 2'd1;
  localparam logic [1:0] ACT_CLIP  = 2'd2;
  localparam logic [1:0] ACT_LEAKY = 2'd3;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [11:0] frame_height;
    logic [1:0]  padding;
  } geom_t;

  typedef struct packed {
    logic [NTAPS-1:0][15:0] weights;
    logic [15:0]            bias;
    logic [1:0]             act_mode;
    logic [15:0]            clip_min;
    logic [15:0]            clip_max;
    logic [15:0]            slope;
  } act_cfg_t;

  typedef struct packed {
    logic [NTAPS-1:0][15:0] taps;
    logic [NTAPS-1:0]       mask;
    logic                   row_end;
    logic                   frame_end;
    logic                   last;
  } job_t;

endpackage

### hw/rtl/dwc_stream_if.sv
`timescale 1ns / 1ps
interface dwc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] sample;
  modport source (output valid, output mode, output sample, input ready);
  modport sink (input valid, input mode, input sample, output ready);
endinterface

interface dwc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic               row_end;
  logic               frame_end;
  logic               last;
  modport source (output valid, output value, output row_end, output frame_end,
                  output last, input ready);
  modport sink (input valid, input value, input row_end, input frame_end,
                input last, output ready);
endinterface

### hw/rtl/dwc_front.sv
`timescale 1ns / 1ps
module dwc_front
  import dwc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  geom_t       geom,
  dwc_in_if.sink      in_ch,
  output job_t        job,
  output logic        job_valid,
  input  logic        job_ready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic signed [15:0] MAXW_S = 16'(MAX_WIDTH);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_UPD   = 2'd1;
  localparam logic [1:0] F_PUSH0 = 2'd2;
  localparam logic [1:0] F_PUSH1 = 2'd3;

  logic [1:0]             state;
  logic [CW-1:0]          in_col;
  logic [11:0]            in_row;
  logic                   hold_mode;
  logic [15:0]            hold_sample;
  logic [15:0]            mid_q;
  logic [15:0]            top_q;
  logic [NTAPS-1:0][15:0] window;
  job_t                   job0;
  job_t                   job1;
  logic                   has0;
  logic                   has1;

  logic [15:0] mid_mem [MAX_WIDTH];
  logic [15:0] top_mem [MAX_WIDTH];

  logic signed [15:0]     gw, gh, rr, cc, oh, ow, ow_n, oh_n;
  logic                   pc, pr, drain, ignore, emit0, emit1;
  logic [15:0]            bot;
  logic [NTAPS-1:0][15:0] nw, t1;
  logic [NTAPS-1:0]       m0, m1;
  logic [CW-1:0]          in_col_next;
  logic [11:0]            in_row_next;
  job_t                   job0_next, job1_next;

  assign in_ch.ready = (state == F_IDLE);

  always_comb begin
    logic signed [15:0] row;
    logic signed [15:0] col;
    logic               row_ok;
    gw = $signed({5'd0, geom.frame_width});
    if (gw < 16'sd3) begin
      gw = 16'sd3;
    end else if (gw > MAXW_S) begin
      gw = MAXW_S;
    end
    gh = $signed({4'd0, geom.frame_height});
    if (gh < 16'sd3) begin
      gh = 16'sd3;
    end
    pc = geom.padding[0];
    pr = geom.padding[1];
    rr = $signed({4'd0, in_row});
    cc = $signed(16'(in_col));
    drain = (rr >= gh);
    ignore = !drain && hold_mode;
    bot = drain ? 16'd0 : hold_sample;

    for (int kh = 0; kh < KERNEL_SIZE; kh++) begin
      nw[kh*3]     = window[kh*3+1];
      nw[kh*3 + 1] = window[kh*3+2];
    end
    nw[2] = top_q;
    nw[5] = mid_q;
    nw[8] = bot;

    for (int kh = 0; kh < KERNEL_SIZE; kh++) begin
      row = rr - 16'sd2 + 16'(kh);
      row_ok = (row >= 16'sd0) && (row < gh);
      for (int kw = 0; kw < KERNEL_SIZE; kw++) begin
        col = cc - 16'sd2 + 16'(kw);
        m0[kh*3 + kw] = row_ok && (col >= 16'sd0) && (col < gw);
        if (kw < 2) begin
          col = cc - 16'sd1 + 16'(kw);
          m1[kh*3 + kw] = row_ok && (col >= 16'sd0) && (col < gw);
          t1[kh*3 + kw] = nw[kh*3 + kw + 1];
        end else begin
          m1[kh*3 + kw] = 1'b0;
          t1[kh*3 + kw] = 16'd0;
        end
      end
    end

    oh   = rr - 16'sd2 + $signed({15'd0, pr});
    ow   = cc - 16'sd2 + $signed({15'd0, pc});
    ow_n = gw + $signed({14'd0, pc, 1'b0}) - 16'sd2;
    oh_n = gh + $signed({14'd0, pr, 1'b0}) - 16'sd2;
    emit0 = (oh >= 16'sd0) && (oh < oh_n) && (ow >= 16'sd0) && (ow < ow_n);
    emit1 = (oh >= 16'sd0) && (oh < oh_n) && pc && (cc == gw - 16'sd1);

    job0_next.taps      = nw;
    job0_next.mask      = m0;
    job0_next.row_end   = (ow == ow_n - 16'sd1);
    job0_next.frame_end = (ow == ow_n - 16'sd1) && (oh == oh_n - 16'sd1);
    job0_next.last      = !emit1;
    job1_next.taps      = t1;
    job1_next.mask      = m1;
    job1_next.row_end   = 1'b1;
    job1_next.frame_end = (oh == oh_n - 16'sd1);
    job1_next.last      = 1'b1;

    if (cc >= gw - 16'sd1) begin
      in_col_next = '0;
      if (drain) begin
        in_row_next = '0;
      end else if (rr == gh - 16'sd1) begin
        in_row_next = pr ? gh[11:0] : 12'd0;
      end else begin
        in_row_next = in_row + 12'd1;
      end
    end else begin
      in_col_next = in_col + CW'(1);
      in_row_next = in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      mid_q <= mid_mem[in_col];
      top_q <= top_mem[in_col];
    end
    if (state == F_UPD && !ignore) begin
      top_mem[in_col] <= mid_q;
      mid_mem[in_col] <= bot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      in_col <= '0;
      in_row <= '0;
      window <= '0;
      has0   <= 1'b0;
      has1   <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_ch.valid) begin
            hold_mode   <= in_ch.mode;
            hold_sample <= in_ch.sample;
            state       <= F_UPD;
          end
        end
        F_UPD: begin
          job0  <= job0_next;
          job1  <= job1_next;
          has0  <= !ignore && emit0;
          has1  <= !ignore && emit1;
          state <= F_PUSH0;
          if (!ignore) begin
            window <= nw;
            in_col <= in_col_next;
            in_row <= in_row_next;
          end
        end
        F_PUSH0: begin
          if (!has0 || job_ready) begin
            state <= F_PUSH1;
          end
        end
        F_PUSH1: begin
          if (!has1 || job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign job_valid = ((state == F_PUSH0) && has0) || ((state == F_PUSH1) && has1);
  assign job       = (state == F_PUSH0) ? job0 : job1;

endmodule

### hw/rtl/dwc_queue.sv
`timescale 1ns / 1ps
module dwc_queue
  import dwc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  job_t push_data,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_data,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != NW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

### hw/rtl/dwc_back.sv
`timescale 1ns / 1ps
`include "depthwise_conv3x3_act_defines.svh"
module dwc_back
  import dwc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  act_cfg_t acfg,
  input  job_t     job,
  input  logic     job_valid,
  output logic     job_pop,
  dwc_out_if.source out_ch
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MAC  = 3'd1;
  localparam logic [2:0] B_ACT  = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_RND  = 3'd4;

  logic [2:0]                state;
  job_t                      cur;
  logic [3:0]                k;
  logic signed [31:0]        prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [LPROD_W-1:0] lprod;
  logic                      ovalid;
  logic signed [15:0]        ovalue;
  logic                      orow_end, oframe_end, olast;

  logic signed [ACC_W-1:0]   clip_lo, clip_hi, act_acc;
  logic signed [23:0]        rnd;
  logic signed [15:0]        sat;
  logic signed [LPROD_W-1:0] lsum;
  logic signed [ACC_W-1:0]   nsum;
  logic                      out_free;

  assign job_pop  = (state == B_IDLE) && job_valid;
  assign out_free = !ovalid || out_ch.ready;

  always_comb begin
    clip_lo = ACC_W'($signed(acfg.clip_min)) <<< 14;
    clip_hi = ACC_W'($signed(acfg.clip_max)) <<< 14;
    act_acc = acc;
    unique case (acfg.act_mode)
      ACT_RELU: begin
        if (acc < 0) begin
          act_acc = '0;
        end
      end
      ACT_CLIP: begin
        if (acc < clip_lo) begin
          act_acc = clip_lo;
        end
        if (act_acc > clip_hi) begin
          act_acc = clip_hi;
        end
      end
      ACT_NONE, ACT_LEAKY: act_acc = acc;
      default: act_acc = acc;
    endcase

    lsum = lprod + (LPROD_W'(1) <<< 27);
    nsum = acc + (ACC_W'(1) <<< 13);
    if (acfg.act_mode == ACT_LEAKY && acc < 0) begin
      rnd = lsum[51:28];
    end else begin
      rnd = 24'(nsum >>> 14);
    end
    if (rnd > 24'sd32767) begin
      sat = 16'sd32767;
    end else if (rnd < -24'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
      k      <= '0;
    end else begin
      if (ovalid && out_ch.ready && (state != B_RND)) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            acc   <= ACC_W'($signed(acfg.bias)) <<< 14;
            prod  <= '0;
            k     <= '0;
            state <= B_MAC;
          end
        end
        B_MAC: begin
          acc <= acc + ACC_W'(prod);
          if (k < 4'd9) begin
            prod <= cur.mask[k] ?
                    $signed(acfg.weights[k]) * $signed(cur.taps[k]) : 32'sd0;
            k    <= k + 4'd1;
          end else begin
            state <= B_ACT;
          end
        end
        B_ACT: begin
          acc   <= act_acc;
          state <= B_MUL;
        end
        B_MUL: begin
          lprod <= acc * $signed(acfg.slope);
          state <= B_RND;
        end
        B_RND: begin
          if (out_free) begin
            ovalid     <= 1'b1;
            ovalue     <= sat;
            orow_end   <= cur.row_end;
            oframe_end <= cur.frame_end;
            olast      <= cur.last;
            state      <= B_IDLE;
          end else begin
            ovalid     <= ovalid;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = ovalid;
  assign out_ch.value     = ovalue;
  assign out_ch.row_end   = orow_end;
  assign out_ch.frame_end = oframe_end;
  assign out_ch.last      = olast;

  `DWC_ASSERT_NOW(a_pop_when_idle, job_pop, state == B_IDLE)
  `DWC_ASSERT_NOW(a_step_range, state == B_MAC, k <= 4'd9)
  `DWC_ASSERT_NEXT(a_result_shown, (state == B_RND) && out_free, (state == B_IDLE) && ovalid)

endmodule

### hw/rtl/depthwise_conv3x3_act.sv
`timescale 1ns / 1ps
// Streaming 3x3 stride-1 convolution of one Q8.8 channel plane with bias and activation.
// The front accepts an item only when idle and takes no new one until it is through with
// the last: it reads the two line stores on acceptance, updates the window, classifies
// the item and offers its up to two results to a four-entry queue, waiting while it is
// full. The back takes a job when idle, runs the nine products through one 16x16
// multiplier and accumulates them, then come activation, the leaky multiply and rounding
// into the output register, which waits until the previous result is taken. The slower
// back sets the pace of a sustained stream. The line stores need no clearing pass after
// reset; item acceptance starts in the first cycle after reset.
module depthwise_conv3x3_act
  import dwc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  dwc_in_if.sink      in_ch,
  dwc_out_if.source   out_ch
);

  logic [63:0] taps_first_four;
  logic [63:0] taps_next_four;
  logic [31:0] tap_last_and_bias;
  logic [1:0]  act_mode;
  logic [47:0] act_params;
  geom_t       geom;
  act_cfg_t    acfg;
  job_t        fq_job, qb_job;
  logic        fq_valid, fq_ready, qb_valid, qb_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_first_four   <= '0;
      taps_next_four    <= '0;
      tap_last_and_bias <= '0;
      act_mode          <= ACT_NONE;
      act_params        <= '0;
      geom.frame_width  <= 11'd1024;
      geom.frame_height <= 12'd1024;
      geom.padding      <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAPS_A:    taps_first_four   <= cfg_data;
        CFG_TAPS_B:    taps_next_four    <= cfg_data;
        CFG_TAP8_BIAS: tap_last_and_bias <= cfg_data[31:0];
        CFG_ACT_MODE:  act_mode          <= cfg_data[1:0];
        CFG_ACT_PARAM: act_params        <= cfg_data[47:0];
        CFG_WIDTH:     geom.frame_width  <= cfg_data[10:0];
        CFG_HEIGHT:    geom.frame_height <= cfg_data[11:0];
        CFG_PADDING:   geom.padding      <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acfg.weights[i]     = taps_first_four[16*i +: 16];
      acfg.weights[i + 4] = taps_next_four[16*i +: 16];
    end
    acfg.weights[8] = tap_last_and_bias[15:0];
    acfg.bias       = tap_last_and_bias[31:16];
    acfg.act_mode   = act_mode;
    acfg.clip_min   = act_params[15:0];
    acfg.clip_max   = act_params[31:16];
    acfg.slope      = act_params[47:32];
  end

  dwc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .in_ch     (in_ch),
    .job       (fq_job),
    .job_valid (fq_valid),
    .job_ready (fq_ready)
  );

  dwc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (fq_job),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_data   (qb_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_pop)
  );

  dwc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .acfg      (acfg),
    .job       (qb_job),
    .job_valid (qb_valid),
    .job_pop   (qb_pop),
    .out_ch    (out_ch)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import dwc_pkg::*;

  typedef struct {
    logic [15:0] value;
    logic        row_end;
    logic        frame_end;
    logic        last;
  } conv_out_t;

  class dwc_scoreboard;
    longint unsigned regs[8];
    logic [15:0]     lines[2*DEF_MAX_WIDTH];
    logic [15:0]     win[NTAPS];
    int              in_col, in_row;
    conv_out_t       owed[$];
    int              errors;

    function new();
      regs = '{default: 0};
      regs[CFG_WIDTH] = 1024;
      regs[CFG_HEIGHT] = 1024;
      regs[CFG_PADDING] = 3;
      foreach (lines[i]) lines[i] = '0;
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, longint unsigned v);
      case (idx)
        CFG_TAP8_BIAS: regs[idx] = v & 64'hFFFF_FFFF;
        CFG_ACT_MODE:  regs[idx] = v & 64'h3;
        CFG_ACT_PARAM: regs[idx] = v & 64'hFFFF_FFFF_FFFF;
        CFG_WIDTH:     regs[idx] = v & 64'h7FF;
        CFG_HEIGHT:    regs[idx] = v & 64'hFFF;
        CFG_PADDING:   regs[idx] = v & 64'h3;
        default:       regs[idx] = v;
      endcase
    endfunction

    function longint sx16(longint unsigned v);
      logic signed [15:0] h;
      h = v[15:0];
      return longint'(h);
    endfunction

    function longint tap_weight(int i);
      if (i < 4) return sx16(regs[CFG_TAPS_A] >> (16 * i));
      if (i < 8) return sx16(regs[CFG_TAPS_B] >> (16 * (i - 4)));
      return sx16(regs[CFG_TAP8_BIAS]);
    endfunction

    function logic [15:0] convolve(int r, int c, int shift, int W, int H);
      longint acc, lo, hi, res;
      int     row, col, src;
      logic [1:0] act;
      acc = sx16(regs[CFG_TAP8_BIAS] >> 16) * 16384;
      act = regs[CFG_ACT_MODE][1:0];
      for (int kh = 0; kh < KERNEL_SIZE; kh++) begin
        row = r - 2 + kh;
        if (row < 0 || row >= H) continue;
        for (int kw = 0; kw < KERNEL_SIZE; kw++) begin
          src = kw + shift;
          col = c - 2 + src;
          if (src >= KERNEL_SIZE || col < 0 || col >= W) continue;
          acc += tap_weight(kh * KERNEL_SIZE + kw) * sx16(win[kh * KERNEL_SIZE + src]);
        end
      end
      if (act == ACT_RELU && acc < 0) acc = 0;
      if (act == ACT_CLIP) begin
        lo = sx16(regs[CFG_ACT_PARAM]) * 16384;
        hi = sx16(regs[CFG_ACT_PARAM] >> 16) * 16384;
        if (acc < lo) acc = lo;
        if (acc > hi) acc = hi;
      end
      if (act == ACT_LEAKY && acc < 0)
        res = (acc * sx16(regs[CFG_ACT_PARAM] >> 32) + (64'sd1 <<< 27)) >>> 28;
      else
        res = (acc + 8192) >>> 14;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res[15:0];
    endfunction

    function int width();
      int W;
      W = int'(regs[CFG_WIDTH]);
      if (W < 3) W = 3;
      if (W > DEF_MAX_WIDTH) W = DEF_MAX_WIDTH;
      return W;
    endfunction

    function int height();
      int H;
      H = int'(regs[CFG_HEIGHT]);
      if (H < 3) H = 3;
      return H;
    endfunction

    function void note_input(logic mode, logic [15:0] s);
      int W, H, pc, pr, r, c, OW, OH, oh, ow, n;
      logic [15:0] top, mid, bot;
      conv_out_t   res[2];
      W = width();
      H = height();
      pc = int'(regs[CFG_PADDING][0]);
      pr = int'(regs[CFG_PADDING][1]);
      r = in_row;
      c = in_col;
      OW = W + 2 * pc - 2;
      OH = H + 2 * pr - 2;
      n = 0;
      if (r < H && mode) return;
      bot = (r >= H) ? 16'h0 : s;
      top = '0;
      mid = '0;
      if (c < DEF_MAX_WIDTH) begin
        mid = lines[c];
        top = lines[DEF_MAX_WIDTH + c];
        lines[DEF_MAX_WIDTH + c] = mid;
        lines[c] = bot;
      end
      for (int kh = 0; kh < KERNEL_SIZE; kh++) begin
        win[kh*3] = win[kh*3 + 1];
        win[kh*3 + 1] = win[kh*3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = bot;
      oh = r - 2 + pr;
      ow = c - 2 + pc;
      if (oh >= 0 && oh < OH) begin
        if (ow >= 0 && ow < OW) begin
          res[n].value = convolve(r, c, 0, W, H);
          res[n].row_end = (ow == OW - 1);
          res[n].frame_end = (ow == OW - 1 && oh == OH - 1);
          n++;
        end
        if (pc && c == W - 1) begin
          res[n].value = convolve(r, c, 1, W, H);
          res[n].row_end = 1'b1;
          res[n].frame_end = (oh == OH - 1);
          n++;
        end
      end
      for (int k = 0; k < n; k++) begin
        res[k].last = (k == n - 1);
        owed.push_back(res[k]);
      end
      if (c >= W - 1) begin
        in_col = 0;
        if (r >= H) in_row = 0;
        else if (r == H - 1) in_row = pr ? H : 0;
        else in_row = r + 1;
      end else begin
        in_col = c + 1;
      end
    endfunction

    function void check_result(conv_out_t got);
      conv_out_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result value %h row_end %b frame_end %b last %b",
                 $time, got.value, got.row_end, got.frame_end, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value expected %h actual %h", $time, want.value, got.value);
        errors++;
      end
      if (got.row_end !== want.row_end) begin
        $display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                 got.frame_end);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  dwc_in_if    in_ch();
  dwc_out_if   out_ch();

  depthwise_conv3x3_act DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  dwc_scoreboard conv_sb;
  bit            steady;
  int            quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_wide();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < 4; i++) v[16*i +: 16] = 16'(int'($urandom_range(0, 32767)) - 16384);
    end
    return v;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    conv_sb.write_reg(idx, v);
  endtask

  task automatic configure(int W, int H, int pad, logic [1:0] act);
    write_reg(CFG_TAPS_A, pick_wide());
    write_reg(CFG_TAPS_B, pick_wide());
    write_reg(CFG_TAP8_BIAS, pick_wide());
    write_reg(CFG_ACT_MODE, 64'(act));
    write_reg(CFG_ACT_PARAM, pick_wide());
    write_reg(CFG_WIDTH, 64'(W));
    write_reg(CFG_HEIGHT, 64'(H));
    write_reg(CFG_PADDING, 64'(pad));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (conv_sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_item(logic mode, logic [15:0] s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    conv_sb.note_input(mode, s);
  endtask

  // Feeds the current plane until it wraps back to its first sample or the count runs out.
  task automatic feed_plane(int max_items, int noise_pct);
    int sent;
    sent = 0;
    do begin
      if (conv_sb.in_row >= conv_sb.height())
        send_item(1'($urandom_range(0, 1)), pick_sample());
      else if ($urandom_range(0, 99) < noise_pct)
        send_item(1'b1, pick_sample());
      else
        send_item(1'b0, pick_sample());
      sent++;
    end while (sent < max_items && !(conv_sb.in_row == 0 && conv_sb.in_col == 0));
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic plane(int W, int H, int pad, logic [1:0] act, int noise_pct);
    wait_idle();
    configure(W, H, pad, act);
    steady = ($urandom_range(0, 3) == 0);
    feed_plane(1 << 30, noise_pct);
  endtask

  initial begin
    int total;
    conv_sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_TAPS_A;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.sample = '0;
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed planes: each activation, every padding, clip with min above max.
    plane(3, 3, 3, ACT_NONE, 0);
    plane(3, 3, 0, ACT_RELU, 10);
    wait_idle();
    configure(3, 3, 2, ACT_CLIP);
    write_reg(CFG_ACT_PARAM, 64'h0000_0000_8000_7FFF);
    cfg_we <= 1'b0;
    @(posedge clk);
    feed_plane(1 << 30, 0);
    plane(3, 3, 1, ACT_LEAKY, 0);

    // Width change in the middle of a plane, made while the block is idle.
    wait_idle();
    configure(8, 6, 0, ACT_NONE);
    feed_plane(19, 0);
    wait_idle();
    write_reg(CFG_WIDTH, 64'd5);
    cfg_we <= 1'b0;
    @(posedge clk);
    feed_plane(1 << 30, 0);

    // Width and height below and above their bounds; the wide plane is left partway through
    // its second row and the next plane takes over its counters.
    wait_idle();
    configure(2047, 0, 1, ACT_RELU);
    feed_plane(1100, 0);
    plane(1, 2, 3, ACT_CLIP, 5);

    total = 0;
    while (total < 500) begin
      int W, H;
      W = $urandom_range(3, 12);
      H = $urandom_range(3, 8);
      total += (W + 1) * (H + 1);
      plane(W, H, $urandom_range(0, 3), 2'($urandom_range(0, 3)), 8);
    end

    while (conv_sb.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (conv_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int stall;
    conv_out_t got;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.value = out_ch.value;
      got.row_end = out_ch.row_end;
      got.frame_end = out_ch.frame_end;
      got.last = out_ch.last;
      conv_sb.check_result(got);
    end
  end
endmodule

### depthwise_conv3x3_act.f
+incdir+hw/rtl
hw/rtl/dwc_pkg.sv
hw/rtl/dwc_stream_if.sv
hw/rtl/dwc_front.sv
hw/rtl/dwc_queue.sv
hw/rtl/dwc_back.sv
hw/rtl/depthwise_conv3x3_act.sv
verif/testbench.sv
